// ----- src/rv32im_execute_alu_assert.svh -----
`ifndef RV32IM_EXECUTE_ALU_ASSERT_SVH
`define RV32IM_EXECUTE_ALU_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ALU_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error("alu check failed");

// Checks that a condition implies a consequence in the next cycle.
`define ALU_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("alu check failed");

`endif

// ----- src/rvalu_pkg.sv -----
package rvalu_pkg;

    localparam int XLEN = 32;
    localparam int DIV_STEPS = 32;

    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_DIVU = 5'd5;
    localparam logic [4:0] OP_REM  = 5'd6;
    localparam logic [4:0] OP_REMU = 5'd7;
    localparam logic [4:0] OP_SLL  = 5'd8;
    localparam logic [4:0] OP_SRA  = 5'd9;
    localparam logic [4:0] OP_SRL  = 5'd10;
    localparam logic [4:0] OP_OR   = 5'd11;
    localparam logic [4:0] OP_XOR  = 5'd12;
    localparam logic [4:0] OP_AND  = 5'd13;
    localparam logic [4:0] OP_SLT  = 5'd14;
    localparam logic [4:0] OP_SLTU = 5'd15;
    localparam logic [4:0] OP_CMP  = 5'd16;

    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Word carried down the divider chain; flags are {ltu, lt, eq}.
    typedef struct packed {
        logic              use_div;
        logic              sel_rem;
        logic              neg_out;
        logic [XLEN-1:0]   res;
        logic [2:0]        flags;
        logic [XLEN:0]     rem;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   dvs;
    } div_word_t;

endpackage

// ----- src/rvalu_prep.sv -----
module rvalu_prep (
    input  logic [4:0]              op,
    input  logic [31:0]             left_operand,
    input  logic [31:0]             right_operand,
    input  logic [1:0]              mem_op,
    output rvalu_pkg::div_word_t    word
);
    import rvalu_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] sum;
    logic        slt;
    logic        sltu;
    logic        mem_force;
    logic        is_div_op;

    assign a = left_operand;
    assign b = right_operand;
    assign sh = b[4:0];
    assign sum = a + b;
    assign slt = $signed(a) < $signed(b);
    assign sltu = a < b;
    assign mem_force = (mem_op == MEM_LOAD) || (mem_op == MEM_STORE);
    assign mag_a = a[31] ? (32'd0 - a) : a;
    assign mag_b = b[31] ? (32'd0 - b) : b;
    assign is_div_op = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM) || (op == OP_REMU);

    always_comb begin
        word = '0;
        word.rem = '0;
        case (op)
            OP_ADD:  word.res = sum;
            OP_SUB:  word.res = a - b;
            OP_MUL:  word.res = a * b;
            OP_SLL:  word.res = a << sh;
            OP_SRA:  word.res = $unsigned($signed(a) >>> sh);
            OP_SRL:  word.res = a >> sh;
            OP_OR:   word.res = a | b;
            OP_XOR:  word.res = a ^ b;
            OP_AND:  word.res = a & b;
            OP_SLT:  word.res = {31'd0, slt};
            OP_SLTU: word.res = {31'd0, sltu};
            OP_CMP:  word.flags = {sltu, slt, a == b};
            default: word.res = '0;
        endcase
        // Signed ops divide magnitudes and fix the sign at the end of the chain.
        case (op)
            OP_DIV: begin
                word.quo = mag_a;
                word.dvs = mag_b;
                word.neg_out = a[31] ^ b[31];
            end
            OP_REM: begin
                word.quo = mag_a;
                word.dvs = mag_b;
                word.neg_out = a[31];
                word.sel_rem = 1'b1;
            end
            OP_REMU: begin
                word.quo = a;
                word.dvs = b;
                word.sel_rem = 1'b1;
            end
            default: begin
                word.quo = a;
                word.dvs = b;
            end
        endcase
        word.use_div = is_div_op && (b != 32'd0) && !mem_force;
        if (mem_force) begin
            word.res = sum;
        end
    end

endmodule

// ----- src/rvalu_div_cell.sv -----
module rvalu_div_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  rvalu_pkg::div_word_t    in_word,
    output logic                    out_valid,
    output rvalu_pkg::div_word_t    out_word
);
    import rvalu_pkg::*;

    logic        valid_reg;
    div_word_t   word_reg;
    div_word_t   word_next;
    logic [XLEN:0]   shifted;
    logic [XLEN+1:0] diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {in_word.rem[XLEN-1:0], in_word.quo[XLEN-1]};
    assign diff = {1'b0, shifted} - {2'b00, in_word.dvs};

    always_comb begin
        word_next = in_word;
        if (!diff[XLEN+1]) begin
            word_next.rem = diff[XLEN:0];
            word_next.quo = {in_word.quo[XLEN-2:0], 1'b1};
        end else begin
            word_next.rem = shifted;
            word_next.quo = {in_word.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;

endmodule

// ----- src/rv32im_execute_alu.sv -----
// Channel | Ports          | tdata (low bit up)              | tuser (low bit up)
// input   | s_tvalid/tready| left_operand, right_operand     | op, mem_op
// result  | m_tvalid/tready| alu_result                      | eq_flag, lt_flag, ltu_flag
//
// One word is accepted per cycle while no result stalls; each word passes through
// stage0, 32 divider cells (one quotient bit per cell) and the output register.
// All operations travel the same chain, so results leave in input order.
// Reset is synchronous on aresetn low and empties the chain.
// A stalled result freezes the whole chain, and s_tready drops with it.
module rv32im_execute_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_operand[31:0], right_operand[63:32]
    input  logic [6:0]  s_tuser,   // op[4:0], mem_op[6:5]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // alu_result[31:0]
    output logic [2:0]  m_tuser    // eq_flag[0], lt_flag[1], ltu_flag[2]
);
    import rvalu_pkg::*;

    logic        en;
    div_word_t   prep_word;
    logic        stage0_valid_reg;
    div_word_t   stage0_word_reg;
    logic        chain_valid [DIV_STEPS+1];
    div_word_t   chain_word [DIV_STEPS+1];
    logic [31:0] div_val;
    logic [31:0] result_next;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    div_word_t   last;

    assign en = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    rvalu_prep u_prep (
        .op            (s_tuser[4:0]),
        .left_operand  (s_tdata[31:0]),
        .right_operand (s_tdata[63:32]),
        .mem_op        (s_tuser[6:5]),
        .word          (prep_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage0_valid_reg <= 1'b0;
        end else if (en) begin
            stage0_valid_reg <= s_tvalid;
        end
        if (en) begin
            stage0_word_reg <= prep_word;
        end
    end

    assign chain_valid[0] = stage0_valid_reg;
    assign chain_word[0] = stage0_word_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        rvalu_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    assign last = chain_word[DIV_STEPS];

    always_comb begin
        if (last.sel_rem) begin
            div_val = last.rem[31:0];
        end else begin
            div_val = last.quo;
        end
        if (last.neg_out) begin
            div_val = 32'd0 - div_val;
        end
        result_next = last.use_div ? div_val : last.res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain_valid[DIV_STEPS];
        end
        if (en) begin
            m_tdata_reg <= result_next;
            m_tuser_reg <= last.flags;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

`include "rv32im_execute_alu_assert.svh"

    `ALU_ASSERT_NOW(a_ready_follows_output, m_tvalid && !m_tready, !s_tready)
    `ALU_ASSERT_NOW(a_eq_excludes_lt, m_tvalid && m_tuser[0], !m_tuser[1] && !m_tuser[2])
    `ALU_ASSERT_NEXT(a_chain_advances, stage0_valid_reg && en, chain_valid[1])
    `ALU_ASSERT_NEXT(a_stall_freezes_chain, !en, $stable(stage0_valid_reg))

endmodule

// ----- sim/rv32im_execute_alu_tb.sv -----
module rv32im_execute_alu_tb;
    import rvalu_pkg::*;

    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [1:0]  mem;
    } alu_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        eq;
        logic        lt;
        logic        ltu;
    } alu_out_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [6:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    alu_word_t pending_words[$];
    alu_out_t  expected_outs[$];
    int        errors = 0;
    int        checked = 0;
    int        send_idle_pct = 18;
    int        recv_idle_pct = 68;
    bit        hold_send = 0;
    int        quiet_cycles = 0;

    rv32im_execute_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 0) return 0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic alu_out_t alu_predict(alu_word_t w);
        alu_out_t o;
        logic [4:0] sh;
        logic [63:0] prod;
        o = '0;
        sh = w.rhs[4:0];
        case (w.op)
            OP_ADD:  o.value = w.lhs + w.rhs;
            OP_SUB:  o.value = w.lhs - w.rhs;
            OP_MUL: begin
                prod = {32'b0, w.lhs} * {32'b0, w.rhs};
                o.value = prod[31:0];
            end
            OP_DIV:  o.value = sdiv(w.lhs, w.rhs, 1'b0);
            OP_DIVU: o.value = (w.rhs != 0) ? w.lhs / w.rhs : 0;
            OP_REM:  o.value = sdiv(w.lhs, w.rhs, 1'b1);
            OP_REMU: o.value = (w.rhs != 0) ? w.lhs % w.rhs : 0;
            OP_SLL:  o.value = w.lhs << sh;
            OP_SRA:  o.value = $unsigned($signed(w.lhs) >>> sh);
            OP_SRL:  o.value = w.lhs >> sh;
            OP_OR:   o.value = w.lhs | w.rhs;
            OP_XOR:  o.value = w.lhs ^ w.rhs;
            OP_AND:  o.value = w.lhs & w.rhs;
            OP_SLT:  o.value = {31'b0, $signed(w.lhs) < $signed(w.rhs)};
            OP_SLTU: o.value = {31'b0, w.lhs < w.rhs};
            OP_CMP: begin
                o.eq = w.lhs == w.rhs;
                o.lt = $signed(w.lhs) < $signed(w.rhs);
                o.ltu = w.lhs < w.rhs;
            end
            default: o.value = 0;
        endcase
        if (w.mem == MEM_LOAD || w.mem == MEM_STORE) o.value = w.lhs + w.rhs;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic [1:0] m);
        alu_word_t w;
        w.op = op;
        w.lhs = a;
        w.rhs = b;
        w.mem = m;
        pending_words.push_back(w);
    endtask

    // Driver: a word leaves the queue only when the handshake completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_outs.push_back(alu_predict(pending_words.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1;
            end else if (pending_words.size() > (s_tvalid && s_tready ? 0 : 0) && !hold_send
                         && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1;
                s_tdata <= {pending_words[0].rhs, pending_words[0].lhs};
                s_tuser <= {pending_words[0].mem, pending_words[0].op};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Monitor and receiver backpressure.
    always @(posedge aclk) begin
        alu_out_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_outs.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    errors++;
                end else begin
                    e = expected_outs.pop_front();
                    if (m_tdata !== e.value) begin
                        $error("alu_result expected %h got %h", e.value, m_tdata); errors++;
                    end
                    if (m_tuser[0] !== e.eq) begin
                        $error("eq_flag expected %b got %b", e.eq, m_tuser[0]); errors++;
                    end
                    if (m_tuser[1] !== e.lt) begin
                        $error("lt_flag expected %b got %b", e.lt, m_tuser[1]); errors++;
                    end
                    if (m_tuser[2] !== e.ltu) begin
                        $error("ltu_flag expected %b got %b", e.ltu, m_tuser[2]); errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", expected_outs.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_outs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic wait_until_half();
        while (pending_words.size() > 90) @(posedge aclk);
    endtask

    initial begin
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // Directed corners: every op, division by zero, signed overflow, memory codes.
        for (int op = 0; op <= 16; op++)
            add_word(5'(op), 32'h8000_0000, 32'hFFFF_FFFF, 2'd0);
        add_word(OP_DIV, 32'h1234_5678, 32'd0, 2'd0);
        add_word(OP_REMU, 32'hFFFF_FFFF, 32'd0, 2'd0);
        add_word(OP_REM, 32'hFFFF_FFF9, 32'd2, 2'd0);
        add_word(OP_CMP, 32'h5, 32'h5, 2'd0);
        add_word(OP_SRA, 32'h8000_0000, 32'hFFFF_FFFF, 2'd0);
        add_word(OP_MUL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, MEM_LOAD);
        add_word(OP_CMP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, MEM_STORE);
        add_word(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 18 : 0;
            for (int i = 0; i < 185; i++)
                add_word(5'($urandom_range(0, 99) < 90 ? $urandom_range(0, 16)
                                                       : $urandom_range(17, 31)),
                         pick_operand(), pick_operand(),
                         2'($urandom_range(0, 99) < 75 ? 0 : $urandom_range(1, 3)));
            wait_until_half();
            hold_send = 1;
            while (expected_outs.size() != 0 || s_tvalid) @(posedge aclk);
            hold_send = 0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d result words over all ops, corner operands and memory codes,", checked);
        $display("under three sender and receiver stall mixes.");
        if (errors == 0 && expected_outs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+src
src/rvalu_pkg.sv
src/rvalu_prep.sv
src/rvalu_div_cell.sv
src/rv32im_execute_alu.sv
sim/rv32im_execute_alu_tb.sv
